// ===== rtl/wind_window_average_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef WIND_WINDOW_AVERAGE_UNIT_MACROS_SVH
`define WIND_WINDOW_AVERAGE_UNIT_MACROS_SVH

// Implication check sampled on the rising clock, idle in reset.
`define WWA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication check sampled on the rising clock, idle in reset.
`define WWA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wwa_pkg.sv =====
// Shared types, constants and tables for the wind window average unit.
package wwa_pkg;

   localparam int SPEED_W  = 16;
   localparam int DIR_W    = 9;
   localparam int CORDIC_STEPS = 16;
   localparam int STEP_W   = 4;
   localparam int ZW       = 26;  // degrees Q16 accumulator, signed
   localparam int CW       = 28;  // CORDIC x/y width, signed
   localparam int COMP_W   = 16;  // component sums, signed
   localparam logic signed [ZW-1:0] DEG90_Q16  = ZW'(90 * 65536);
   localparam logic signed [ZW-1:0] DEG45_Q16  = ZW'(45 * 65536);
   localparam logic signed [ZW-1:0] DEG180_Q16 = ZW'(180 * 65536);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_SCAN,
      ST_DIV,
      ST_ANGLE_SETUP,
      ST_CORDIC,
      ST_FINISH,
      ST_HOLD
   } wwa_state_type;

   typedef struct packed {
      logic load;       // capture request, update ring index and fill count
      logic scan_start;
      logic scan_step;
      logic div_start;
      logic angle_setup;
      logic cordic_step;
      logic finish;
   } wwa_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic div_done;
      logic cordic_last;
   } wwa_status_type;

   function automatic logic [6:0] sin_tab(input logic [6:0] d);
      logic [6:0] r;
      unique case (d)
         7'd0: r = 7'd0;   7'd1: r = 7'd1;   7'd2: r = 7'd3;   7'd3: r = 7'd5;
         7'd4: r = 7'd6;   7'd5: r = 7'd8;   7'd6: r = 7'd10;  7'd7: r = 7'd12;
         7'd8: r = 7'd13;  7'd9: r = 7'd15;  7'd10: r = 7'd17; 7'd11: r = 7'd19;
         7'd12: r = 7'd20; 7'd13: r = 7'd22; 7'd14: r = 7'd24; 7'd15: r = 7'd25;
         7'd16: r = 7'd27; 7'd17: r = 7'd29; 7'd18: r = 7'd30; 7'd19: r = 7'd32;
         7'd20: r = 7'd34; 7'd21: r = 7'd35; 7'd22: r = 7'd37; 7'd23: r = 7'd39;
         7'd24: r = 7'd40; 7'd25: r = 7'd42; 7'd26: r = 7'd43; 7'd27: r = 7'd45;
         7'd28: r = 7'd46; 7'd29: r = 7'd48; 7'd30: r = 7'd50; 7'd31: r = 7'd51;
         7'd32: r = 7'd52; 7'd33: r = 7'd54; 7'd34: r = 7'd55; 7'd35: r = 7'd57;
         7'd36: r = 7'd58; 7'd37: r = 7'd60; 7'd38: r = 7'd61; 7'd39: r = 7'd62;
         7'd40: r = 7'd64; 7'd41: r = 7'd65; 7'd42: r = 7'd66; 7'd43: r = 7'd68;
         7'd44: r = 7'd69; 7'd45: r = 7'd70; 7'd46: r = 7'd71; 7'd47: r = 7'd73;
         7'd48: r = 7'd74; 7'd49: r = 7'd75; 7'd50: r = 7'd76; 7'd51: r = 7'd77;
         7'd52: r = 7'd78; 7'd53: r = 7'd79; 7'd54: r = 7'd80; 7'd55: r = 7'd81;
         7'd56: r = 7'd82; 7'd57: r = 7'd83; 7'd58: r = 7'd84; 7'd59: r = 7'd85;
         7'd60: r = 7'd86; 7'd61: r = 7'd87; 7'd62: r = 7'd88; 7'd63: r = 7'd89;
         7'd64: r = 7'd89; 7'd65: r = 7'd90; 7'd66: r = 7'd91; 7'd67: r = 7'd92;
         7'd68: r = 7'd92; 7'd69: r = 7'd93; 7'd70: r = 7'd93; 7'd71: r = 7'd94;
         7'd72: r = 7'd95; 7'd73: r = 7'd95; 7'd74: r = 7'd96; 7'd75: r = 7'd96;
         7'd76: r = 7'd97; 7'd77: r = 7'd97; 7'd78: r = 7'd97; 7'd79: r = 7'd98;
         7'd80: r = 7'd98; 7'd81: r = 7'd98; 7'd82: r = 7'd99; 7'd83: r = 7'd99;
         7'd84: r = 7'd99; 7'd85: r = 7'd99; 7'd86: r = 7'd99; 7'd87: r = 7'd99;
         7'd88: r = 7'd99; 7'd89: r = 7'd99;
         default: r = 7'd100;
      endcase
      return r;
   endfunction

   // trunc(100*sin(d)) for d in 0..359
   function automatic logic signed [7:0] sin100(input logic [8:0] d);
      logic signed [7:0] r;
      if (d <= 9'd90)       r = $signed({1'b0, sin_tab(d[6:0])});
      else if (d <= 9'd180) r = $signed({1'b0, sin_tab(7'(9'd180 - d))});
      else if (d <= 9'd270) r = -$signed({1'b0, sin_tab(7'(d - 9'd180))});
      else                  r = -$signed({1'b0, sin_tab(7'(9'd360 - d))});
      return r;
   endfunction

   function automatic logic [8:0] mod360(input logic [9:0] d);
      logic [9:0] r;
      r = d;
      if (r >= 10'd360) r = r - 10'd360;
      if (r >= 10'd360) r = r - 10'd360;
      return r[8:0];
   endfunction

   function automatic logic signed [ZW-1:0] atan_q16(input logic [STEP_W-1:0] i);
      logic signed [ZW-1:0] r;
      unique case (i)
         4'd0: r = ZW'(2949120);  4'd1: r = ZW'(1740967);
         4'd2: r = ZW'(919879);   4'd3: r = ZW'(466945);
         4'd4: r = ZW'(234379);   4'd5: r = ZW'(117304);
         4'd6: r = ZW'(58666);    4'd7: r = ZW'(29335);
         4'd8: r = ZW'(14668);    4'd9: r = ZW'(7334);
         4'd10: r = ZW'(3667);    4'd11: r = ZW'(1833);
         4'd12: r = ZW'(917);     4'd13: r = ZW'(458);
         4'd14: r = ZW'(229);     default: r = ZW'(115);
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/wwa_ctrl.sv =====
// Sequencer for the wind window average unit.
module wwa_ctrl
   import wwa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output wwa_cmd_type    cmd,
   input  wwa_status_type status
);

   wwa_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:        if (req_valid) state_in = ST_WRITE;
         ST_WRITE:       state_in = ST_SCAN;
         ST_SCAN:        if (status.scan_last) state_in = ST_DIV;
         ST_DIV:         if (status.div_done) state_in = ST_ANGLE_SETUP;
         ST_ANGLE_SETUP: state_in = ST_CORDIC;
         ST_CORDIC:      if (status.cordic_last) state_in = ST_FINISH;
         ST_FINISH:      state_in = ST_HOLD;
         ST_HOLD:        if (rsp_ready) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_WRITE:       cmd.scan_start  = 1'b1;
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.div_start = status.scan_last;
         end
         ST_DIV:         ;
         ST_ANGLE_SETUP: cmd.angle_setup = 1'b1;
         ST_CORDIC:      cmd.cordic_step = 1'b1;
         ST_FINISH:      cmd.finish      = 1'b1;
         ST_HOLD:        rsp_valid       = 1'b1;
         default:        ;
      endcase
   end

endmodule

// ===== rtl/wwa_datapath.sv =====
// Rings, accumulators, dividers and CORDIC for the wind window average unit.
module wwa_datapath
   import wwa_pkg::*;
#(
   parameter int WINDOW = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  wwa_cmd_type         cmd,
   output wwa_status_type      status,
   input  logic [SPEED_W-1:0]  req_wind_speed,
   input  logic [DIR_W-1:0]    req_wind_direction,
   output logic [SPEED_W-1:0]  rsp_mean_speed,
   output logic [SPEED_W-1:0]  rsp_gust_speed,
   output logic [DIR_W-1:0]    rsp_mean_direction
);

   localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int NW  = $clog2(WINDOW + 1);
   localparam int SUMW = SPEED_W + NW;
   localparam int CSW = 8 + NW + 1;          // component sum width, signed
   localparam int QW  = (SUMW > CSW) ? SUMW : CSW;
   localparam int DCW = $clog2(QW + 1);

   logic [SPEED_W-1:0] speed_mem [WINDOW];
   logic [DIR_W-1:0]   dir_mem   [WINDOW];
   logic [IW-1:0] wr_idx_ff;
   logic [NW-1:0] fill_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          rd_live_ff;
   logic [SPEED_W-1:0] rd_speed_ff;
   logic [DIR_W-1:0]   rd_dir_ff;
   logic [SPEED_W-1:0] spd_hold_ff;
   logic [DIR_W-1:0]   dir_hold_ff;

   logic [SUMW-1:0]         sum_ff;
   logic [SPEED_W-1:0]      peak_ff;
   logic signed [CSW-1:0]   sx_ff, sy_ff;
   logic                    last_pending_ff;

   // ring write and bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         fill_ff   <= '0;
      end else if (cmd.load) begin
         wr_idx_ff <= (wr_idx_ff == IW'(WINDOW - 1)) ? '0 : wr_idx_ff + 1'b1;
         if (fill_ff != NW'(WINDOW)) fill_ff <= fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         spd_hold_ff <= req_wind_speed;
         dir_hold_ff <= req_wind_direction;
      end
      if (cmd.scan_start) begin
         speed_mem[wr_idx_ff == '0 ? IW'(WINDOW - 1) : wr_idx_ff - 1'b1] <= spd_hold_ff;
         dir_mem[wr_idx_ff == '0 ? IW'(WINDOW - 1) : wr_idx_ff - 1'b1]   <= dir_hold_ff;
      end
      rd_speed_ff <= speed_mem[rd_idx_ff];
      rd_dir_ff   <= dir_mem[rd_idx_ff];
   end

   // scan: address issued in the cycle before its accumulate
   logic          acc_en_ff;
   logic [NW-1:0] issued_ff;
   logic [8:0]    dmod;
   logic signed [7:0] cx, cy;

   assign dmod = mod360({1'b0, rd_dir_ff});
   assign cy   = sin100(dmod);
   assign cx   = sin100(mod360({1'b0, dmod} + 10'd90));

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_live_ff <= 1'b0;
         acc_en_ff  <= 1'b0;
      end else begin
         rd_live_ff <= cmd.scan_start ||
                       (rd_live_ff && cmd.scan_step && (issued_ff + 1'b1 != fill_ff));
         acc_en_ff  <= rd_live_ff && !cmd.scan_start;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         rd_idx_ff <= '0;
         issued_ff <= '0;
         sum_ff    <= '0;
         peak_ff   <= '0;
         sx_ff     <= '0;
         sy_ff     <= '0;
         last_pending_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (rd_live_ff) begin
            rd_idx_ff <= (rd_idx_ff == IW'(WINDOW - 1)) ? '0 : rd_idx_ff + 1'b1;
            issued_ff <= issued_ff + 1'b1;
            if (issued_ff + 1'b1 == fill_ff) last_pending_ff <= 1'b1;
         end
         if (acc_en_ff) begin
            sum_ff <= sum_ff + SUMW'(rd_speed_ff);
            if (rd_speed_ff > peak_ff) peak_ff <= rd_speed_ff;
            sx_ff <= sx_ff + CSW'(cx);
            sy_ff <= sy_ff + CSW'(cy);
         end
      end
   end

   // read data lands in the cycle after the address; signal the end once the
   // last filled entry has been accumulated
   assign status.scan_last = last_pending_ff && !acc_en_ff && !rd_live_ff;

   // three restoring dividers sharing one bit counter
   logic [DCW-1:0]   div_cnt_ff;
   logic             div_busy_ff;
   logic [QW-1:0]    q_s_ff, q_x_ff, q_y_ff;
   logic [NW:0]      r_s_ff, r_x_ff, r_y_ff;
   logic             neg_x_ff, neg_y_ff;
   logic [NW:0]      r_s_sh, r_x_sh, r_y_sh, den;

   assign den    = {1'b0, fill_ff};
   assign r_s_sh = {r_s_ff[NW-1:0], q_s_ff[QW-1]};
   assign r_x_sh = {r_x_ff[NW-1:0], q_x_ff[QW-1]};
   assign r_y_sh = {r_y_ff[NW-1:0], q_y_ff[QW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == DCW'(QW - 1)) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         div_cnt_ff <= '0;
         q_s_ff   <= QW'(sum_ff);
         q_x_ff   <= QW'(sx_ff[CSW-1] ? -sx_ff : sx_ff);
         q_y_ff   <= QW'(sy_ff[CSW-1] ? -sy_ff : sy_ff);
         neg_x_ff <= sx_ff[CSW-1];
         neg_y_ff <= sy_ff[CSW-1];
         r_s_ff   <= '0;
         r_x_ff   <= '0;
         r_y_ff   <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (r_s_sh >= den) begin
            r_s_ff <= r_s_sh - den;
            q_s_ff <= {q_s_ff[QW-2:0], 1'b1};
         end else begin
            r_s_ff <= r_s_sh;
            q_s_ff <= {q_s_ff[QW-2:0], 1'b0};
         end
         if (r_x_sh >= den) begin
            r_x_ff <= r_x_sh - den;
            q_x_ff <= {q_x_ff[QW-2:0], 1'b1};
         end else begin
            r_x_ff <= r_x_sh;
            q_x_ff <= {q_x_ff[QW-2:0], 1'b0};
         end
         if (r_y_sh >= den) begin
            r_y_ff <= r_y_sh - den;
            q_y_ff <= {q_y_ff[QW-2:0], 1'b1};
         end else begin
            r_y_ff <= r_y_sh;
            q_y_ff <= {q_y_ff[QW-2:0], 1'b0};
         end
      end
   end

   assign status.div_done = div_busy_ff && div_cnt_ff == DCW'(QW - 1);

   // CORDIC vectoring on first-quadrant magnitudes
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [ZW-1:0] z_ff;
   logic [STEP_W-1:0]    step_ff;
   logic                 special_ff;
   logic signed [ZW-1:0] special_z_ff;
   logic                 zero_vec_ff;
   logic [7:0]           ax, ay;
   logic signed [CW-1:0] ysh, xsh;

   assign ax = q_x_ff[7:0];
   assign ay = q_y_ff[7:0];

   // arithmetic shift of a magnitude toward zero
   assign xsh = cx_ff[CW-1] ? -((-cx_ff) >>> step_ff) : (cx_ff >>> step_ff);
   assign ysh = cy_ff[CW-1] ? -((-cy_ff) >>> step_ff) : (cy_ff >>> step_ff);

   always_ff @(posedge clock) begin
      if (cmd.angle_setup) begin
         cx_ff   <= $signed({4'b0, ax, 16'b0});
         cy_ff   <= $signed({4'b0, ay, 16'b0});
         z_ff    <= '0;
         step_ff <= '0;
         zero_vec_ff <= (ax == 8'd0) && (ay == 8'd0);
         special_ff  <= (ay == 8'd0) || (ax == 8'd0) || (ax == ay);
         if (ay == 8'd0)      special_z_ff <= '0;
         else if (ax == 8'd0) special_z_ff <= DEG90_Q16;
         else                 special_z_ff <= DEG45_Q16;
      end else if (cmd.cordic_step) begin
         step_ff <= step_ff + 1'b1;
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + ysh;
            cy_ff <= cy_ff - xsh;
            z_ff  <= z_ff + atan_q16(step_ff);
         end else begin
            cx_ff <= cx_ff - ysh;
            cy_ff <= cy_ff + xsh;
            z_ff  <= z_ff - atan_q16(step_ff);
         end
      end
   end

   assign status.cordic_last = step_ff == STEP_W'(CORDIC_STEPS - 1);

   logic signed [ZW-1:0] t_clamp, m_q;
   logic [DIR_W-1:0]     deg;

   always_comb begin
      if (special_ff)             t_clamp = special_z_ff;
      else if (z_ff < 0)          t_clamp = '0;
      else if (z_ff > DEG90_Q16)  t_clamp = DEG90_Q16;
      else                        t_clamp = z_ff;
      m_q = neg_x_ff ? DEG180_Q16 - t_clamp : t_clamp;
      deg = DIR_W'(m_q >>> 16);
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_mean_speed <= q_s_ff[SPEED_W-1:0];
         rsp_gust_speed <= peak_ff;
         if (zero_vec_ff)                 rsp_mean_direction <= '0;
         else if (neg_y_ff && deg != '0) rsp_mean_direction <= DIR_W'(10'd360 - {1'b0, deg});
         else                             rsp_mean_direction <= deg;
      end
   end

endmodule

// ===== rtl/wind_window_average_unit.sv =====
// Top level of the wind window average unit.
// Usage:
//  Requests arrive on req_valid/req_ready with req_wind_speed (0.1 m/s) and
//  req_wind_direction (degrees). Each request writes a ring of WINDOW
//  samples and yields one response on rsp_valid/rsp_ready: mean speed, gust
//  (peak) speed and the vector-mean direction over the filled window.
//  One request is worked at a time. With n filled entries (1..WINDOW), the
//  ring write and scan cover those n entries, the shared bit-serial dividers
//  produce one quotient bit per cycle and the CORDIC runs setup, 16
//  iterations and the output register. The scan, the dividers and the
//  CORDIC together set the rate: the next request is accepted only once
//  the response to the previous one has been taken.
//  Reset empties the window (fill count and write index to zero); ring
//  contents need no clearing, since only written entries are read.
//  While the receiver stalls, the response holds and req_ready stays low.
module wind_window_average_unit
   import wwa_pkg::*;
#(
   parameter int WINDOW = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [SPEED_W-1:0] req_wind_speed,
   input  logic [DIR_W-1:0]   req_wind_direction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [SPEED_W-1:0] rsp_mean_speed,
   output logic [SPEED_W-1:0] rsp_gust_speed,
   output logic [DIR_W-1:0]   rsp_mean_direction
);

   wwa_cmd_type    cmd;
   wwa_status_type status;

   wwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   wwa_datapath #(.WINDOW(WINDOW)) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_wind_speed     (req_wind_speed),
      .req_wind_direction (req_wind_direction),
      .rsp_mean_speed     (rsp_mean_speed),
      .rsp_gust_speed     (rsp_gust_speed),
      .rsp_mean_direction (rsp_mean_direction)
   );

endmodule

// ===== rtl/wwa_checker.sv =====
// Port-level checker for the wind window average unit, with its bind.
`include "wind_window_average_unit_macros.svh"
module wwa_checker
   import wwa_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SPEED_W-1:0] rsp_mean_speed,
   input logic [SPEED_W-1:0] rsp_gust_speed,
   input logic [DIR_W-1:0]   rsp_mean_direction
);

   `WWA_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, !req_ready, "request taken while response pending")
   `WWA_ASSERT_IMP(a_mean_le_gust, clock, reset, rsp_valid, rsp_mean_speed <= rsp_gust_speed, "mean above gust")
   `WWA_ASSERT_IMP(a_dir_range, clock, reset, rsp_valid, rsp_mean_direction < 9'd360, "direction out of range")
   `WWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mean_direction), "response dropped")

endmodule

bind wind_window_average_unit wwa_checker u_wwa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_mean_speed     (rsp_mean_speed),
   .rsp_gust_speed     (rsp_gust_speed),
   .rsp_mean_direction (rsp_mean_direction)
);

// ===== test/tb_top.sv =====
// Testbench for the wind window average unit: directed table plus random requests.
`timescale 1ns / 100ps

module tb_top
   import wwa_pkg::*;
();

   localparam int WIN = 16;
   localparam int N_RANDOM = 750;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [SPEED_W-1:0] speed;
      logic [DIR_W-1:0]   dir;
   } sample_type;

   typedef struct packed {
      logic [SPEED_W-1:0] mean;
      logic [SPEED_W-1:0] gust;
      logic [DIR_W-1:0]   dir;
   } stats_type;

   typedef struct {
      logic [SPEED_W-1:0] speed;
      logic [DIR_W-1:0]   dir;
      bit                 has_fixed;
      stats_type          fixed;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [SPEED_W-1:0] req_wind_speed = '0;
   logic [DIR_W-1:0] req_wind_direction = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [SPEED_W-1:0] rsp_mean_speed;
   logic [SPEED_W-1:0] rsp_gust_speed;
   logic [DIR_W-1:0] rsp_mean_direction;

   wind_window_average_unit #(.WINDOW(WIN)) dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // predictor state
   logic [SPEED_W-1:0] speed_hist [WIN];
   logic [DIR_W-1:0] dir_hist [WIN];
   int hist_wr = 0;
   int hist_fill = 0;

   stats_type expected_stats [$];
   int errors = 0;
   int responses = 0;
   longint cycles = 0;

   function automatic int sin_tab_tb(int d);
      int q [91] = '{
         0, 1, 3, 5, 6, 8, 10, 12, 13, 15, 17, 19, 20, 22, 24, 25, 27, 29, 30, 32,
         34, 35, 37, 39, 40, 42, 43, 45, 46, 48, 50, 51, 52, 54, 55, 57, 58, 60, 61, 62,
         64, 65, 66, 68, 69, 70, 71, 73, 74, 75, 76, 77, 78, 79, 80, 81, 82, 83, 84, 85,
         86, 87, 88, 89, 89, 90, 91, 92, 92, 93, 93, 94, 95, 95, 96, 96, 97, 97, 97, 98,
         98, 98, 99, 99, 99, 99, 99, 99, 99, 99, 100};
      return q[d];
   endfunction

   function automatic int comp100(int d);
      int r;
      d = d % 360;
      if (d <= 90) r = sin_tab_tb(d);
      else if (d <= 180) r = sin_tab_tb(180 - d);
      else if (d <= 270) r = -sin_tab_tb(d - 180);
      else r = -sin_tab_tb(360 - d);
      return r;
   endfunction

   function automatic longint shift_tz(longint v, int s);
      if (v >= 0) return v >>> s;
      return -((-v) >>> s);
   endfunction

   function automatic longint quadrant_angle(longint ax, longint ay);
      longint arc [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      longint x, y, z, nx, ny;
      if (ay == 0) return 0;
      if (ax == 0) return 90 * 65536;
      if (ax == ay) return 45 * 65536;
      x = ax * 65536;
      y = ay * 65536;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         if (y > 0) begin
            nx = x + shift_tz(y, i);
            ny = y - shift_tz(x, i);
            z += arc[i];
         end else begin
            nx = x - shift_tz(y, i);
            ny = y + shift_tz(x, i);
            z -= arc[i];
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return z;
   endfunction

   function automatic int vector_direction(int x, int y);
      longint ax, ay, t, m;
      int deg;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      if (ax == 0 && ay == 0) return 0;
      t = quadrant_angle(ax, ay);
      m = (x >= 0) ? t : 180 * 65536 - t;
      deg = int'(m >>> 16);
      if (y < 0 && deg != 0) return 360 - deg;
      return deg;
   endfunction

   function automatic stats_type window_stats(sample_type s);
      stats_type r;
      longint total;
      int peak, sx, sy;
      if (hist_fill < WIN) hist_fill++;
      speed_hist[hist_wr] = s.speed;
      dir_hist[hist_wr] = s.dir;
      hist_wr = (hist_wr + 1) % WIN;
      total = 0;
      peak = 0;
      sx = 0;
      sy = 0;
      for (int i = 0; i < hist_fill; i++) begin
         total += speed_hist[i];
         if (speed_hist[i] > peak) peak = speed_hist[i];
         sx += comp100(dir_hist[i] + 90);
         sy += comp100(dir_hist[i]);
      end
      sx = sx / hist_fill;
      sy = sy / hist_fill;
      r.mean = SPEED_W'(total / hist_fill);
      r.gust = SPEED_W'(peak);
      r.dir = DIR_W'(vector_direction(sx, sy));
      return r;
   endfunction

   // drive on the falling edge; keep valid high when no idle cycles are drawn
   task automatic send_request(logic [SPEED_W-1:0] spd, logic [DIR_W-1:0] dir,
                               bit has_fixed, stats_type fixed);
      stats_type p;
      sample_type s;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_wind_speed <= spd;
      req_wind_direction <= dir;
      s.speed = spd;
      s.dir = dir;
      do @(posedge clock); while (!req_ready);
      p = window_stats(s);
      if (has_fixed && p != fixed) begin
         $display("%0t: table row disagrees with predictor (spd %0d dir %0d)",
                  $time, spd, dir);
         errors++;
      end
      expected_stats.push_back(has_fixed ? fixed : p);
   endtask

   // response side: random stall per response
   initial begin
      int stall;
      stats_type e;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         responses++;
         if (expected_stats.size() == 0) begin
            $display("%0t: response with none pending: %0d %0d %0d", $time,
                     rsp_mean_speed, rsp_gust_speed, rsp_mean_direction);
            errors++;
         end else begin
            e = expected_stats.pop_front();
            if (rsp_mean_speed !== e.mean) begin
               $display("%0t: mean_speed exp %0d got %0d", $time, e.mean, rsp_mean_speed);
               errors++;
            end
            if (rsp_gust_speed !== e.gust) begin
               $display("%0t: gust_speed exp %0d got %0d", $time, e.gust, rsp_gust_speed);
               errors++;
            end
            if (rsp_mean_direction !== e.dir) begin
               $display("%0t: mean_direction exp %0d got %0d", $time, e.dir,
                        rsp_mean_direction);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   row_type table_rows [$];

   function automatic row_type mk(int spd, int dir, bit fx = 0, int m = 0, int g = 0,
                                  int d = 0);
      row_type r;
      r.speed = SPEED_W'(spd);
      r.dir = DIR_W'(dir);
      r.has_fixed = fx;
      r.fixed.mean = SPEED_W'(m);
      r.fixed.gust = SPEED_W'(g);
      r.fixed.dir = DIR_W'(d);
      return r;
   endfunction

   initial begin
      stats_type none;
      int k, base, spread;
      none = '{default: '0};
      // first sample after reset: result is the sample itself on the axes
      table_rows.push_back(mk(0, 0, 1, 0, 0, 0));
      table_rows.push_back(mk(65535, 180, 1, 32767, 65535, 0));
      table_rows.push_back(mk(65535, 0));
      table_rows.push_back(mk(100, 90));
      table_rows.push_back(mk(1, 270));
      table_rows.push_back(mk(65535, 359));
      table_rows.push_back(mk(0, 45));
      table_rows.push_back(mk(300, 135));
      table_rows.push_back(mk(32768, 225));
      table_rows.push_back(mk(7, 315));
      table_rows.push_back(mk(65535, 1));
      table_rows.push_back(mk(12345, 179));
      table_rows.push_back(mk(500, 181));
      table_rows.push_back(mk(21845, 256));
      table_rows.push_back(mk(43690, 511 - 152));
      table_rows.push_back(mk(255, 91));
      // ring wraps from here on
      table_rows.push_back(mk(65535, 0));
      table_rows.push_back(mk(65535, 180));
      table_rows.push_back(mk(0, 90));
      table_rows.push_back(mk(0, 270));
      table_rows.push_back(mk(1, 2));
      // directions past a full turn wrap around
      table_rows.push_back(mk(900, 450));
      table_rows.push_back(mk(901, 511));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (table_rows[i])
         send_request(table_rows[i].speed, table_rows[i].dir, table_rows[i].has_fixed,
                      table_rows[i].has_fixed ? table_rows[i].fixed : none);

      // random: clustered directions, axis directions at high speed, and uniform or skewed noise
      for (k = 0; k < N_RANDOM; k++) begin
         base = $urandom_range(0, 359);
         spread = $urandom_range(0, 3);
         unique case (spread)
            0: send_request(SPEED_W'($urandom), DIR_W'($urandom_range(0, 359)), 0, none);
            1: send_request(SPEED_W'($urandom_range(0, 300)),
                            DIR_W'((base + $urandom_range(0, 20)) % 360), 0, none);
            2: send_request(SPEED_W'($urandom_range(65000, 65535)),
                            DIR_W'(($urandom_range(0, 1) ? 180 : 0) + $urandom_range(0, 2)
                                   * 90 % 180), 0, none);
            default: send_request(SPEED_W'($urandom), DIR_W'($urandom_range(0, 1) ?
                                  $urandom_range(0, 359) : $urandom_range(300, 359)),
                                  0, none);
         endcase
      end
      @(negedge clock);
      req_valid <= 0;

      while (expected_stats.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d requests (directed table then random), checked %0d responses.",
               table_rows.size() + N_RANDOM, responses);
      if (errors == 0 && expected_stats.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
